[sv/abef_pkg.sv]
// Shared constants, pixel and divider types for the alpha bleed edge fill block.
package abef_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int FW_W      = 13;
    localparam int FH_W      = 16;
    localparam int CMP_W     = (COL_W + 1 > FW_W) ? COL_W + 1 : FW_W;
    localparam int CH_W      = 8;
    localparam int SA_W      = 10;
    localparam int SC_W      = 18;
    localparam int OUT_COL_W = 12;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int NB_SLOTS  = 4;
    localparam int SLOT_W    = $clog2(NB_SLOTS);
    localparam int PIX_W     = 4 * CH_W;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic [CH_W-1:0] alpha;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } pix_t;

    typedef struct packed {
        logic                  start;
        logic [SA_W-1:0]       den;
        logic [2:0][SC_W-1:0]  num;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [2:0][CH_W-1:0]  quot;
    } div_rsp_t;

    function automatic logic [OUT_COL_W-1:0] col_to_out(input logic [COL_W-1:0] col);
        logic [COL_W+OUT_COL_W-1:0] wide;
        wide = {{OUT_COL_W{1'b0}}, col};
        return wide[OUT_COL_W-1:0];
    endfunction

endpackage

[sv/abef_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module abef_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[sv/abef_div.sv]
// Three-lane restoring divider sharing one divisor, one quotient bit per cycle.
module abef_div import abef_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int STEP_W = $clog2(CH_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CH_W - 1);

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [SA_W-1:0]     den_reg;
    logic [SA_W-1:0]     rem_reg  [3];
    logic [CH_W-1:0]     qr_reg   [3];
    logic [SA_W-1:0]     rem_next [3];
    logic [CH_W-1:0]     qr_next  [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [SA_W:0] trial;
            logic [SA_W:0] diff;
            logic          ge;
            trial = {rem_reg[i], qr_reg[i][CH_W-1]};
            diff  = trial - {1'b0, den_reg};
            ge    = (trial >= {1'b0, den_reg});
            rem_next[i] = ge ? diff[SA_W-1:0] : trial[SA_W-1:0];
            qr_next[i]  = {qr_reg[i][CH_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            den_reg <= req.den;
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[i] <= req.num[i][SC_W-1:CH_W];
                qr_reg[i]  <= req.num[i][CH_W-1:0];
            end
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[i] <= rem_next[i];
                qr_reg[i]  <= qr_next[i];
            end
        end
    end

    always_comb
    begin
        rsp.done = done_reg;
        for (int i = 0; i < 3; i++)
        begin
            rsp.quot[i] = qr_reg[i];
        end
    end

endmodule

[sv/alpha_bleed_edge_fill_unit.sv]
// Alpha bleed edge fill: top level with line stores, sequencer and output register.
//
// Pixels enter on in_valid/in_stall in row order; each accepted word is one RGBA8 pixel.
// Filled pixels leave on out_valid/out_stall with their column and row. The pixel at
// (c, r-1) leaves after pixel (c, r) is taken; the last row leaves one pixel behind the
// input, and the frame's last pixel, flagged by frame_done, follows its own input.
// One input word causes up to three output words.
// Each input word is worked on in steps: the line store reads, then per result four serial
// neighbour accumulation steps and, for a filled result, the bit-serial divider; the reads
// are serial because each line store has a single read port (three reads of the previous
// row store per pixel).
// in_stall is high while a word is being worked on.
// When out_stall holds the output register, the sequencer waits at the next result.
// Reset clears the counters, returns frame_width to 4096 and frame_height to 1; the line
// stores are not cleared; their contents are used only where this frame wrote them.
// A write to either register restarts the frame at column 0, row 0; write only when idle.
module alpha_bleed_edge_fill_unit import abef_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [CH_W-1:0]      in_red,
    input  logic [CH_W-1:0]      in_green,
    input  logic [CH_W-1:0]      in_blue,
    input  logic [CH_W-1:0]      in_alpha,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [OUT_COL_W-1:0] out_column,
    output logic [FH_W-1:0]      out_row,
    output logic [CH_W-1:0]      out_red,
    output logic [CH_W-1:0]      out_green,
    output logic [CH_W-1:0]      out_blue,
    output logic [CH_W-1:0]      out_alpha,
    output logic                 frame_done
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RDA  = 4'd1;
    localparam logic [3:0] S_RDB  = 4'd2;
    localparam logic [3:0] S_RDC  = 4'd3;
    localparam logic [3:0] S_RDD  = 4'd4;
    localparam logic [3:0] S_JOB  = 4'd5;
    localparam logic [3:0] S_ACC  = 4'd6;
    localparam logic [3:0] S_DEC  = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    localparam logic [1:0] JOB_ABOVE = 2'd0;
    localparam logic [1:0] JOB_LEFT  = 2'd1;
    localparam logic [1:0] JOB_LAST  = 2'd2;

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NB_SLOTS - 1);

    logic [3:0]        state_reg, state_next;
    logic [FW_W-1:0]   frame_width_reg;
    logic [FH_W-1:0]   frame_height_reg;
    logic [COL_W-1:0]  column_count_reg;
    logic [FH_W-1:0]   row_count_reg;

    logic [COL_W-1:0]  col_reg;
    logic [FH_W-1:0]   row_reg;
    pix_t              px_reg;
    pix_t              left_pixel_reg;
    pix_t              self_reg;
    pix_t              up_reg;
    pix_t              ol_reg;
    pix_t              pr_reg;
    pix_t              pl_reg;
    pix_t              result_reg;
    logic [2:0]        jobs_reg;
    logic [1:0]        job_sel_reg;
    logic              up_ok_reg, left_ok_reg, right_ok_reg, left2_ok_reg, row_ok_reg;
    logic              col_last_reg, row_last_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [SA_W-1:0]   sa_reg;
    logic [SC_W-1:0]   sc_reg [3];

    logic                 out_valid_reg;
    logic [OUT_COL_W-1:0] out_column_reg;
    logic [FH_W-1:0]      out_row_reg;
    pix_t                 out_pix_reg;
    logic                 out_done_reg;

    logic [CMP_W-1:0]  w_eff;
    logic [FH_W-1:0]   h_eff;
    logic [CMP_W-1:0]  c_ext;
    logic [COL_W-1:0]  c_use;
    logic [CMP_W-1:0]  cu_ext;
    logic [FH_W-1:0]   r_use;
    logic              last_row;
    logic              in_accept;
    logic              out_load;

    logic [COL_W-1:0]  older_rd_addr, prev_rd_addr;
    logic [PIX_W-1:0]  older_rd_data, prev_rd_data;
    logic              ram_we;

    pix_t              self_pix;
    pix_t              nb_pix [NB_SLOTS];
    logic              nb_ok  [NB_SLOTS];
    pix_t              cur_pix;
    logic [CH_W-1:0]   cur_a;
    logic              do_fill;

    div_req_t          div_req;
    div_rsp_t          div_rsp;

    always_comb
    begin
        logic [CMP_W-1:0] wr;
        wr = CMP_W'(frame_width_reg);
        if (wr == '0)
        begin
            w_eff = CMP_W'(1);
        end
        else if (wr > CMP_W'(MAX_WIDTH))
        begin
            w_eff = CMP_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = wr;
        end
        h_eff  = (frame_height_reg == '0) ? FH_W'(1) : frame_height_reg;
        c_ext  = CMP_W'(column_count_reg);
        c_use  = (c_ext >= w_eff) ? '0 : column_count_reg;
        cu_ext = CMP_W'(c_use);
        r_use  = (row_count_reg >= h_eff) ? '0 : row_count_reg;
        last_row = (r_use == h_eff - FH_W'(1));
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_accept) state_next = S_RDA;
            S_RDA:   state_next = S_RDB;
            S_RDB:   state_next = S_RDC;
            S_RDC:   state_next = S_RDD;
            S_RDD:   state_next = S_JOB;
            S_JOB:   state_next = (jobs_reg == 3'b000) ? S_IDLE : S_ACC;
            S_ACC:   if (slot_reg == SLOT_LAST) state_next = S_DEC;
            S_DEC:   state_next = do_fill ? S_DIV : S_OUT;
            S_DIV:   if (div_rsp.done) state_next = S_OUT;
            S_OUT:   if (out_load) state_next = S_JOB;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        older_rd_addr = col_reg;
        prev_rd_addr  = col_reg;
        unique case (state_reg)
            S_RDB:
            begin
                older_rd_addr = col_reg - COL_W'(1);
                prev_rd_addr  = col_reg + COL_W'(1);
            end
            S_RDC:   prev_rd_addr = col_reg - COL_W'(2);
            default: ;
        endcase
    end

    assign ram_we = (state_reg == S_RDD);

    abef_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (col_reg),
        .wr_data (self_reg),
        .rd_addr (older_rd_addr),
        .rd_data (older_rd_data)
    );

    abef_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_prev_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (col_reg),
        .wr_data (px_reg),
        .rd_addr (prev_rd_addr),
        .rd_data (prev_rd_data)
    );

    always_comb
    begin
        for (int i = 0; i < NB_SLOTS; i++)
        begin
            nb_pix[i] = '0;
            nb_ok[i]  = 1'b0;
        end
        unique case (job_sel_reg)
            JOB_ABOVE:
            begin
                self_pix  = self_reg;
                nb_pix[0] = up_reg;         nb_ok[0] = up_ok_reg;
                nb_pix[1] = ol_reg;         nb_ok[1] = left_ok_reg;
                nb_pix[2] = pr_reg;         nb_ok[2] = right_ok_reg;
                nb_pix[3] = px_reg;         nb_ok[3] = 1'b1;
            end
            JOB_LEFT:
            begin
                self_pix  = left_pixel_reg;
                nb_pix[0] = pl_reg;         nb_ok[0] = left2_ok_reg;
                nb_pix[1] = ol_reg;         nb_ok[1] = row_ok_reg;
                nb_pix[2] = px_reg;         nb_ok[2] = 1'b1;
            end
            JOB_LAST:
            begin
                self_pix  = px_reg;
                nb_pix[0] = left_pixel_reg; nb_ok[0] = left_ok_reg;
                nb_pix[1] = self_reg;       nb_ok[1] = row_ok_reg;
            end
            default: self_pix = px_reg;
        endcase
        cur_pix = nb_ok[slot_reg] ? nb_pix[slot_reg] : '0;
        cur_a   = cur_pix.alpha;
        do_fill = (self_pix.alpha == '0) && (sa_reg != '0);
    end

    always_comb
    begin
        div_req.start  = (state_reg == S_DEC) && do_fill;
        div_req.den    = sa_reg;
        div_req.num[0] = sc_reg[0];
        div_req.num[1] = sc_reg[1];
        div_req.num[2] = sc_reg[2];
    end

    abef_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            frame_width_reg  <= FW_W'(4096);
            frame_height_reg <= FH_W'(1);
            column_count_reg <= '0;
            row_count_reg    <= '0;
            jobs_reg         <= '0;
            job_sel_reg      <= JOB_ABOVE;
            slot_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_accept)
            begin
                jobs_reg <= {last_row && (cu_ext == w_eff - CMP_W'(1)),
                             last_row && (c_use != '0),
                             r_use != '0};
            end
            if (state_reg == S_JOB)
            begin
                priority if (jobs_reg[0]) job_sel_reg <= JOB_ABOVE;
                else if (jobs_reg[1])     job_sel_reg <= JOB_LEFT;
                else                      job_sel_reg <= JOB_LAST;
                slot_reg <= '0;
                if (jobs_reg == 3'b000)
                begin
                    if (col_last_reg)
                    begin
                        column_count_reg <= '0;
                        row_count_reg    <= row_last_reg ? '0 : row_reg + FH_W'(1);
                    end
                    else
                    begin
                        column_count_reg <= col_reg + COL_W'(1);
                        row_count_reg    <= row_reg;
                    end
                end
            end
            if (state_reg == S_ACC)
            begin
                slot_reg <= slot_reg + SLOT_W'(1);
            end
            if (out_load)
            begin
                jobs_reg[job_sel_reg] <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FW_W-1:0];
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FH_W-1:0];
                    default: ;
                endcase
                column_count_reg <= '0;
                row_count_reg    <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            px_reg       <= '{alpha: in_alpha, blue: in_blue, green: in_green, red: in_red};
            col_reg      <= c_use;
            row_reg      <= r_use;
            up_ok_reg    <= (r_use >= FH_W'(2));
            left_ok_reg  <= (c_use != '0);
            left2_ok_reg <= (cu_ext >= CMP_W'(2));
            right_ok_reg <= (cu_ext + CMP_W'(1) < w_eff);
            row_ok_reg   <= (r_use != '0);
            col_last_reg <= (cu_ext == w_eff - CMP_W'(1));
            row_last_reg <= last_row;
        end
        unique case (state_reg)
            S_RDB:
            begin
                up_reg   <= older_rd_data;
                self_reg <= prev_rd_data;
            end
            S_RDC:
            begin
                ol_reg <= older_rd_data;
                pr_reg <= prev_rd_data;
            end
            S_RDD:   pl_reg <= prev_rd_data;
            S_JOB:
            begin
                sa_reg <= '0;
                for (int k = 0; k < 3; k++)
                begin
                    sc_reg[k] <= '0;
                end
                if (jobs_reg == 3'b000)
                begin
                    left_pixel_reg <= px_reg;
                end
            end
            S_ACC:
            begin
                sa_reg    <= sa_reg + SA_W'(cur_a);
                sc_reg[0] <= sc_reg[0] + SC_W'({{CH_W{1'b0}}, cur_pix.red}
                                               * {{CH_W{1'b0}}, cur_a});
                sc_reg[1] <= sc_reg[1] + SC_W'({{CH_W{1'b0}}, cur_pix.green}
                                               * {{CH_W{1'b0}}, cur_a});
                sc_reg[2] <= sc_reg[2] + SC_W'({{CH_W{1'b0}}, cur_pix.blue}
                                               * {{CH_W{1'b0}}, cur_a});
            end
            S_DEC:   result_reg <= self_pix;
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    result_reg <= '{alpha: self_pix.alpha, blue: div_rsp.quot[2],
                                    green: div_rsp.quot[1], red: div_rsp.quot[0]};
                end
            end
            default: ;
        endcase
        if (out_load)
        begin
            out_pix_reg  <= result_reg;
            out_done_reg <= (job_sel_reg == JOB_LAST);
            out_row_reg  <= (job_sel_reg == JOB_ABOVE) ? row_reg - FH_W'(1) : row_reg;
            out_column_reg <= col_to_out((job_sel_reg == JOB_LEFT) ? col_reg - COL_W'(1)
                                                                   : col_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_column = out_column_reg;
    assign out_row    = out_row_reg;
    assign out_red    = out_pix_reg.red;
    assign out_green  = out_pix_reg.green;
    assign out_blue   = out_pix_reg.blue;
    assign out_alpha  = out_pix_reg.alpha;
    assign frame_done = out_done_reg;

`ifndef SYNTHESIS
    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_OUT)
        else $error("output word appeared outside the output step");

    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == S_RDA)
        else $error("accepted word did not start the line store reads");

    a_div_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) && div_rsp.done |=> state_reg == S_OUT)
        else $error("quotient ready but result not offered");

    a_jobs_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_JOB) && (jobs_reg == 3'b000) |=> state_reg == S_IDLE)
        else $error("sequencer did not return to idle after last result");
`endif

endmodule
